### hw/rtl/tdchwd_pkg.sv
// Shared types and constants for the TDC hit word decoder.
`timescale 1ns / 1ps

package tdchwd_pkg;

  localparam int NUM_TDC_SLOTS    = 7;
  localparam int CHANNELS_PER_TDC = 49;

  localparam int WORD_W   = 32;
  localparam int ID_W     = 16;
  localparam int SLOT_W   = 3;
  localparam int CHAN_W   = 7;
  localparam int GCH_W    = 9;
  localparam int FINE_W   = 10;
  localparam int COARSE_W = 11;
  localparam int EPOCH_W  = 24;
  localparam int EPT_W    = 44;
  localparam int CT_W     = 20;
  localparam int TIME_W   = 46;
  localparam int TOT_W    = 47;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int unsigned EPOCH_SCALE  = 1024000;
  localparam int unsigned COARSE_SCALE = 500;

  localparam logic [3:0] MARKER_HIT   = 4'h8;
  localparam logic [3:0] MARKER_EPOCH = 4'h6;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK = 4'd7;

  localparam logic [NUM_TDC_SLOTS-1:0][ID_W-1:0] RESET_IDS = {
    16'hE203, 16'hE202, 16'hE201, 16'hE200, 16'hE102, 16'hE101, 16'hE100
  };
  localparam logic [NUM_TDC_SLOTS-1:0] RESET_MASK = '1;

  typedef struct packed {
    logic [NUM_TDC_SLOTS-1:0][ID_W-1:0] ids;
    logic [NUM_TDC_SLOTS-1:0]           mask;
  } cfg_t;

  typedef struct packed {
    logic [GCH_W-1:0]         gch;
    logic                     is_ref;
    logic signed [TIME_W-1:0] lead;
    logic signed [TIME_W-1:0] trail;
  } hit_t;

endpackage

### hw/rtl/tdchwd_cfg_regs.sv
// Configuration register file: slot TDC ids and slot enable mask.
`timescale 1ns / 1ps

module tdchwd_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tdchwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdchwd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tdchwd_pkg::cfg_t                      cfg
);

  tdchwd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ids  <= tdchwd_pkg::RESET_IDS;
      cfg_r.mask <= tdchwd_pkg::RESET_MASK;
    end else if (cfg_valid) begin
      if (cfg_index < tdchwd_pkg::CFG_IDX_W'(tdchwd_pkg::NUM_TDC_SLOTS)) begin
        cfg_r.ids[cfg_index[tdchwd_pkg::SLOT_W-1:0]] <= cfg_data;
      end else if (cfg_index == tdchwd_pkg::CFG_IDX_MASK) begin
        cfg_r.mask <= cfg_data[tdchwd_pkg::NUM_TDC_SLOTS-1:0];
      end
    end
  end

endmodule

### hw/rtl/tdchwd_decode.sv
// Word decode stage: header/epoch/hit decode, block state, hit register.
`timescale 1ns / 1ps

module tdchwd_decode (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tdchwd_pkg::cfg_t                  cfg,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [tdchwd_pkg::WORD_W-1:0]     item_word,
  input  logic                              item_first,
  output logic                              hit_valid,
  input  logic                              hit_ready,
  output tdchwd_pkg::hit_t                  hit
);

  localparam int TIME_W = tdchwd_pkg::TIME_W;
  localparam int EPT_W  = tdchwd_pkg::EPT_W;

  // block state
  logic [EPT_W-1:0]                  ept_r, ept_nxt;
  logic signed [TIME_W-1:0]          ref_r, ref_nxt;
  logic signed [TIME_W-1:0]          rise_r, rise_nxt;
  logic                              exph_r, exph_nxt;
  logic [tdchwd_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic                              match_r, match_nxt;
  logic [15:0]                       block_r, block_nxt;
  logic [15:0]                       widx_r, widx_nxt;

  logic                              hit_valid_r, hit_valid_nxt;
  tdchwd_pkg::hit_t                  hit_r, hit_nxt;

  logic                              adv;
  logic [EPT_W-1:0]                  ept_cur;
  logic signed [TIME_W-1:0]          ref_cur, rise_cur, t, ref_minus_t;
  logic                              exph_cur, is_hdr;
  logic [3:0]                        marker;
  logic [tdchwd_pkg::CHAN_W-1:0]     chan;
  logic                              edge_rise;
  logic [tdchwd_pkg::FINE_W-1:0]     fine;
  logic [tdchwd_pkg::COARSE_W-1:0]   coarse;
  logic [tdchwd_pkg::CT_W-1:0]       coarse_t;
  logic [tdchwd_pkg::GCH_W-1:0]      gch;

  assign item_ready = !hit_valid_r || hit_ready;
  assign adv        = item_valid && item_ready;
  assign hit_valid  = hit_valid_r;
  assign hit        = hit_r;

  assign ept_cur  = item_first ? '0 : ept_r;
  assign ref_cur  = item_first ? '0 : ref_r;
  assign rise_cur = item_first ? '0 : rise_r;
  assign exph_cur = item_first || exph_r;
  assign is_hdr   = exph_cur;

  assign marker    = item_word[31:28];
  assign chan      = item_word[28:22];
  assign edge_rise = item_word[11];
  assign fine      = item_word[21:12];
  assign coarse    = item_word[10:0];
  assign coarse_t  = tdchwd_pkg::CT_W'(coarse) * tdchwd_pkg::CT_W'(tdchwd_pkg::COARSE_SCALE);

  assign t = signed'(TIME_W'(ept_cur)) + signed'(TIME_W'(coarse_t))
           - signed'(TIME_W'(fine));
  assign ref_minus_t = ref_cur - t;

  assign gch = tdchwd_pkg::GCH_W'(slot_r) * tdchwd_pkg::GCH_W'(tdchwd_pkg::CHANNELS_PER_TDC)
             + tdchwd_pkg::GCH_W'(chan);

  always_comb begin
    ept_nxt       = ept_cur;
    ref_nxt       = ref_cur;
    rise_nxt      = rise_cur;
    exph_nxt      = exph_cur;
    slot_nxt      = slot_r;
    match_nxt     = match_r;
    block_nxt     = block_r;
    widx_nxt      = widx_r;
    hit_valid_nxt = 1'b0;
    hit_nxt.gch    = gch;
    hit_nxt.is_ref = 1'b0;
    hit_nxt.lead   = rise_cur;
    hit_nxt.trail  = ref_minus_t;
    if (is_hdr) begin
      block_nxt = item_word[31:16];
      widx_nxt  = '0;
      rise_nxt  = '0;
      exph_nxt  = 1'b0;
      match_nxt = 1'b0;
      slot_nxt  = '0;
      // lowest enabled slot wins
      for (int k = tdchwd_pkg::NUM_TDC_SLOTS - 1; k >= 0; k--) begin
        if (cfg.mask[k] && cfg.ids[k] == item_word[15:0]) begin
          match_nxt = 1'b1;
          slot_nxt  = tdchwd_pkg::SLOT_W'(k);
        end
      end
    end else begin
      if (match_r) begin
        if (marker == tdchwd_pkg::MARKER_HIT) begin
          if (chan == '0) begin
            ref_nxt        = t;
            hit_valid_nxt  = 1'b1;
            hit_nxt.is_ref = 1'b1;
            hit_nxt.lead   = t;
            hit_nxt.trail  = '0;
          end else if (edge_rise) begin
            rise_nxt = ref_minus_t;
          end else if (rise_cur != '0) begin
            hit_valid_nxt = 1'b1;
          end
        end else if (marker == tdchwd_pkg::MARKER_EPOCH) begin
          ept_nxt = EPT_W'(item_word[tdchwd_pkg::EPOCH_W-1:0])
                  * EPT_W'(tdchwd_pkg::EPOCH_SCALE);
        end
      end
      if (block_r != '0 && widx_r == block_r - 16'd1) begin
        exph_nxt = 1'b1;
      end
      widx_nxt = widx_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ept_r       <= '0;
      ref_r       <= '0;
      rise_r      <= '0;
      exph_r      <= 1'b1;
      slot_r      <= '0;
      match_r     <= 1'b0;
      block_r     <= '0;
      widx_r      <= '0;
      hit_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        ept_r   <= ept_nxt;
        ref_r   <= ref_nxt;
        rise_r  <= rise_nxt;
        exph_r  <= exph_nxt;
        slot_r  <= slot_nxt;
        match_r <= match_nxt;
        block_r <= block_nxt;
        widx_r  <= widx_nxt;
      end
      if (item_ready) begin
        hit_valid_r <= adv && hit_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit_valid_nxt) begin
      hit_r <= hit_nxt;
    end
  end

  a_first_takes_header: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_first |=> !exph_r && widx_r == '0 && rise_r == '0)
    else $error("first word not taken as header");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ref_r) && $stable(rise_r) && $stable(ept_r) && $stable(widx_r))
    else $error("block state changed without a request");

  a_paired_needs_rise: assert property (@(posedge clk) disable iff (!rst_n)
    adv && hit_valid_nxt && !hit_nxt.is_ref |=> hit_valid_r && hit_r.lead != '0)
    else $error("paired hit without stored rise");

endmodule

### hw/rtl/tdchwd_out_stage.sv
// Result stage: time over threshold subtract and output register.
`timescale 1ns / 1ps

module tdchwd_out_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 hit_valid,
  output logic                                 hit_ready,
  input  tdchwd_pkg::hit_t                     hit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tdchwd_pkg::hit_t                     out_hit,
  output logic signed [tdchwd_pkg::TOT_W-1:0]  out_tot
);

  localparam int TOT_W = tdchwd_pkg::TOT_W;

  logic                      out_valid_r;
  tdchwd_pkg::hit_t          out_hit_r;
  logic signed [TOT_W-1:0]   tot_r, tot_nxt;

  assign hit_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_tot   = tot_r;

  assign tot_nxt = hit.is_ref ? '0 : (TOT_W'(hit.lead) - TOT_W'(hit.trail));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (hit_ready) begin
      out_valid_r <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_ready && hit_valid) begin
      out_hit_r <= hit;
      tot_r     <= tot_nxt;
    end
  end

endmodule

### hw/rtl/tdc_hit_word_decoder_unit.sv
// Top level of the TDC hit word decoder: input register, decode and result stages.
// Path: a word passes the input register, then the decode stage's hit register, then the output register.
// Throughput: one word per cycle; each stage holds when the next is full and stalled.
// Words that give no result (headers, epochs, rises, foreign blocks) leave no bubble.
// Reset (rst_n low, synchronous): pipeline empty, block state cleared, expects a header,
// slot ids and enable mask back to their defaults.
`timescale 1ns / 1ps

module tdc_hit_word_decoder_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [31:0]                           in_tdata,   // [31:0] data_word
  input  logic                                  in_tuser,   // [0] first_word
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [8:0] global_channel, [54:9] lead_time, [100:55] trail_time,
  // [147:101] time_over_threshold, [151:148] zero
  output logic [151:0]                          out_tdata,
  output logic                                  out_tuser,  // [0] is_reference
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tdchwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdchwd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tdchwd_pkg::cfg_t                       cfg;
  logic                                   s1_valid_r;
  logic [tdchwd_pkg::WORD_W-1:0]          s1_word_r;
  logic                                   s1_first_r;
  logic                                   dec_ready;
  logic                                   hit_valid, hit_ready;
  tdchwd_pkg::hit_t                       hit, out_hit;
  logic signed [tdchwd_pkg::TOT_W-1:0]    out_tot;

  assign in_tready = !s1_valid_r || dec_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r  <= in_tdata;
      s1_first_r <= in_tuser;
    end
  end

  tdchwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdchwd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid_r),
    .item_ready (dec_ready),
    .item_word  (s1_word_r),
    .item_first (s1_first_r),
    .hit_valid  (hit_valid),
    .hit_ready  (hit_ready),
    .hit        (hit)
  );

  tdchwd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit       (hit),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hit   (out_hit),
    .out_tot   (out_tot)
  );

  assign out_tdata = {4'b0000, out_tot, out_hit.trail, out_hit.lead, out_hit.gch};
  assign out_tuser = out_hit.is_ref;

endmodule

### dv/tdc_hit_word_decoder_unit_tb.sv
// Self-checking testbench for the TDC hit word decoder: directed table, then random subevents.
`timescale 1ns / 1ps

module testbench;

  localparam int PHASES      = 5;
  localparam int PHASE_WORDS = 85;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [3:0] {
    REG_SLOT0  = 4'd0,
    REG_ENABLE = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [tdchwd_pkg::GCH_W-1:0]  chan;
    logic                          is_ref;
    logic [tdchwd_pkg::TIME_W-1:0] lead;
    logic [tdchwd_pkg::TIME_W-1:0] trail;
    logic [tdchwd_pkg::TOT_W-1:0]  tot;
  } tot_hit_t;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
    logic        fixed;
    logic        has;
    tot_hit_t    hit;
  } dir_row_t;

  localparam tot_hit_t NO_HIT = '0;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [tdchwd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tdchwd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // decoder model state
  logic [tdchwd_pkg::ID_W-1:0]          slot_id [tdchwd_pkg::NUM_TDC_SLOTS];
  logic [tdchwd_pkg::NUM_TDC_SLOTS-1:0] slot_en;
  logic [tdchwd_pkg::EPOCH_W-1:0]       epoch_r = '0;
  longint                   ref_t = 0;
  longint                   rise_t = 0;
  bit                       want_header = 1'b1;
  bit                       in_slot = 1'b0;
  int                       slot_sel = 0;
  logic [15:0]              blk_len = '0;
  logic [15:0]              blk_pos = '0;

  tot_hit_t pending_hits [$];
  int       fail_count = 0;
  int       quiet_cycles = 0;
  int       gap_pct = 20;
  bit       hold_req = 1'b0;
  int       hold_cnt = 0;

  dir_row_t dir_rows [25] = '{
    '{32'h0000_E100, 1'b1, 1'b1, 1'b0, NO_HIT},  // slot 0, zero length block
    '{32'h8000_0000, 1'b0, 1'b1, 1'b1, '{9'd0, 1'b1, 46'd0, 46'd0, 47'd0}},
    '{32'h6000_0001, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h803F_F7FF, 1'b0, 1'b0, 1'b0, NO_HIT},
    '{32'h8140_080A, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h8140_0014, 1'b0, 1'b0, 1'b0, NO_HIT},
    '{32'h8FFF_F7FF, 1'b0, 1'b0, 1'b0, NO_HIT},  // channel 63 reuses the channel 5 rise
    '{32'h80FF_FFFF, 1'b0, 1'b1, 1'b0, NO_HIT},  // rise at reference time
    '{32'h80C0_0000, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h60FF_FFFF, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h8000_07FF, 1'b0, 1'b0, 1'b0, NO_HIT},
    '{32'h807F_F800, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h8F80_07FF, 1'b0, 1'b0, 1'b0, NO_HIT},
    '{32'hF000_0000, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h0002_E203, 1'b1, 1'b1, 1'b0, NO_HIT},  // slot 6, two words
    '{32'h8000_0001, 1'b0, 1'b1, 1'b1, '{9'd294, 1'b1, 46'd500, 46'd0, 47'd0}},
    '{32'h6000_0000, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'hFFFF_1234, 1'b0, 1'b1, 1'b0, NO_HIT},  // unknown TDC id
    '{32'h8000_0000, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h0003_E200, 1'b1, 1'b1, 1'b0, NO_HIT},
    '{32'h803F_F000, 1'b0, 1'b0, 1'b0, NO_HIT},  // negative time
    '{32'h80BF_F801, 1'b0, 1'b1, 1'b0, NO_HIT},
    '{32'h8080_0002, 1'b0, 1'b0, 1'b0, NO_HIT}
  };

  tdc_hit_word_decoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit decode_word(input logic [31:0] w, input logic first,
                                     output tot_hit_t h);
    logic [tdchwd_pkg::CHAN_W-1:0] chan;
    longint            t;
    longint            trail;
    bit                found;
    h = NO_HIT;
    found = 1'b0;
    if (first) begin
      epoch_r = '0;
      ref_t = 0;
      rise_t = 0;
      want_header = 1'b1;
    end
    if (want_header) begin
      blk_len = w[31:16];
      blk_pos = '0;
      rise_t = 0;
      want_header = 1'b0;
      in_slot = 1'b0;
      slot_sel = 0;
      // scan downward so the lowest enabled match wins
      for (int k = tdchwd_pkg::NUM_TDC_SLOTS - 1; k >= 0; k--) begin
        if (slot_en[k] && slot_id[k] == w[15:0]) begin
          in_slot = 1'b1;
          slot_sel = k;
        end
      end
      return 1'b0;
    end
    if (in_slot) begin
      chan = w[28:22];
      t = longint'(epoch_r) * longint'(tdchwd_pkg::EPOCH_SCALE)
          + longint'(w[10:0]) * longint'(tdchwd_pkg::COARSE_SCALE)
          - longint'(w[21:12]);
      h.chan = 9'(slot_sel * tdchwd_pkg::CHANNELS_PER_TDC + int'(chan));
      if (w[31:28] == tdchwd_pkg::MARKER_HIT) begin
        if (chan == '0) begin
          ref_t = t;
          h.is_ref = 1'b1;
          h.lead = 46'(t);
          found = 1'b1;
        end else if (w[11]) begin
          rise_t = ref_t - t;
        end else if (rise_t != 0) begin
          trail = ref_t - t;
          h.lead = 46'(rise_t);
          h.trail = 46'(trail);
          h.tot = 47'(rise_t - trail);
          found = 1'b1;
        end
      end else if (w[31:28] == tdchwd_pkg::MARKER_EPOCH) begin
        epoch_r = w[23:0];
      end
    end
    if (blk_len != 16'd0 && blk_pos == blk_len - 16'd1) want_header = 1'b1;
    blk_pos = blk_pos + 16'd1;
    return found;
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_word(input logic [31:0] w, input logic first, input bit fixed,
                           input bit fixed_has, input tot_hit_t fixed_hit);
    tot_hit_t h;
    bit       has;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has = decode_word(w, first, h);
    if (fixed) begin
      has = fixed_has;
      h = fixed_hit;
    end
    if (has) pending_hits.insert(pending_hits.size(), h);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [tdchwd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tdchwd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < tdchwd_pkg::NUM_TDC_SLOTS) slot_id[idx] = val;
    else if (idx == REG_ENABLE) slot_en = val[tdchwd_pkg::NUM_TDC_SLOTS-1:0];
    @(negedge clk);
  endtask

  task automatic drain(input int tail);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // result sink with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= gap_pct);
    end
  end

  always @(posedge clk) begin : result_check
    tot_hit_t exp_h;
    tot_hit_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.chan   = out_tdata[8:0];
      got.is_ref = out_tuser;
      got.lead   = out_tdata[54:9];
      got.trail  = out_tdata[100:55];
      got.tot    = out_tdata[147:101];
      if (pending_hits.size() == 0) begin
        $error("unexpected result: global_channel %0d is_reference %0d", got.chan, got.is_ref);
        fail_count++;
      end else begin
        exp_h = pending_hits.pop_front();
        if (got.chan !== exp_h.chan) begin
          $error("global_channel: expected %0d, got %0d", exp_h.chan, got.chan);
          fail_count++;
        end
        if (got.is_ref !== exp_h.is_ref) begin
          $error("is_reference: expected %0d, got %0d", exp_h.is_ref, got.is_ref);
          fail_count++;
        end
        if (got.lead !== exp_h.lead) begin
          $error("lead_time: expected %0d, got %0d", $signed(exp_h.lead), $signed(got.lead));
          fail_count++;
        end
        if (got.trail !== exp_h.trail) begin
          $error("trail_time: expected %0d, got %0d", $signed(exp_h.trail), $signed(got.trail));
          fail_count++;
        end
        if (got.tot !== exp_h.tot) begin
          $error("time_over_threshold: expected %0d, got %0d", $signed(exp_h.tot),
                 $signed(got.tot));
          fail_count++;
        end
        if (out_tdata[151:148] !== 4'd0) begin
          $error("tdata pad: expected 0, got %0h", out_tdata[151:148]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [tdchwd_pkg::ID_W-1:0]          id;
    logic [15:0]                          len;
    logic [tdchwd_pkg::NUM_TDC_SLOTS-1:0] mask;
    logic [31:0]              w;
    int                       sent;
    int                       body;
    int                       pick;
    bit                       clean_end;
    for (int k = 0; k < tdchwd_pkg::NUM_TDC_SLOTS; k++) slot_id[k] = tdchwd_pkg::RESET_IDS[k];
    slot_en = tdchwd_pkg::RESET_MASK;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].first, dir_rows[i].fixed, dir_rows[i].has,
                dir_rows[i].hit);
    in_tvalid <= 1'b0;
    drain(4);

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int k = 0; k < tdchwd_pkg::NUM_TDC_SLOTS; k++) begin
        case (ph)
          0: id = 16'hFFFF;
          1: id = 16'h0000;
          default: begin
            case ($urandom_range(3))
              0: id = 16'h0000;
              1: id = 16'hFFFF;
              default: id = 16'($urandom);
            endcase
          end
        endcase
        write_reg(4'(REG_SLOT0) + 4'(k), id);
      end
      case (ph)
        0: mask = 7'b1010100;
        1: mask = 7'h00;
        2: mask = 7'h7F;
        default: mask = 7'($urandom);
      endcase
      write_reg(REG_ENABLE, 16'(mask) | (16'($urandom) & 16'hFF80));
      write_reg(4'(REG_ENABLE) + 4'($urandom_range(1, 8)), 16'($urandom));
      cfg_valid <= 1'b0;

      gap_pct = (ph == 2) ? 0 : 20;
      if (ph == 3) hold_req = 1'b1;

      sent = 0;
      clean_end = 1'b0;
      while (sent < PHASE_WORDS) begin
        id = ($urandom_range(9) < 8) ? slot_id[$urandom_range(tdchwd_pkg::NUM_TDC_SLOTS - 1)]
                                     : 16'($urandom);
        len = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
        send_word({len, id}, clean_end ? 1'($urandom_range(1)) : ($urandom_range(4) != 0),
                  1'b0, 1'b0, NO_HIT);
        body = (len == 16'd0) ? $urandom_range(1, 12) : int'(len);
        if ($urandom_range(9) == 0) body = $urandom_range(0, body);
        clean_end = (len != 16'd0) && (body == int'(len));
        for (int j = 0; j < body; j++) begin
          pick = $urandom_range(99);
          if (pick < 12)
            w = {tdchwd_pkg::MARKER_EPOCH, 4'($urandom), 24'($urandom)};
          else if (pick < 30)
            w = {tdchwd_pkg::MARKER_HIT, 6'd0, 10'($urandom), 1'($urandom), 11'($urandom)};
          else if (pick < 60)
            w = {tdchwd_pkg::MARKER_HIT, 6'($urandom_range(1, 63)), 10'($urandom), 1'b1,
                 11'($urandom)};
          else if (pick < 95)
            w = {tdchwd_pkg::MARKER_HIT, 6'($urandom_range(1, 63)), 10'($urandom), 1'b0,
                 11'($urandom)};
          else
            w = $urandom;
          send_word(w, 1'b0, 1'b0, 1'b0, NO_HIT);
        end
        sent += 1 + body;
      end
      in_tvalid <= 1'b0;
      drain(4);
    end

    gap_pct = 20;
    drain(10);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
